// ===== hdl/hwtpg_pkg.sv =====
`default_nettype none

package hwtpg_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int FRAME_W   = 32;
    localparam int WIDTH_W   = 9;
    localparam int COLOR_W   = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int HUE_W     = 8;
    localparam int DIFF_W    = 6;
    localparam int SECT_W    = 3;
    localparam int DSUM_W    = 6;

    // Parameter defaults
    localparam int DEF_MAX_COORD_BITS = 8;
    localparam int DEF_CHECKER_CELL   = 8;

    // Rainbow divider: numerator x*255 is 16 bits, retired four bits per stage
    localparam int NUM_W      = 16;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS   = NUM_W / DIV_STAGES;

    localparam int HUE_SPAN = 43;

    // Pattern modes
    localparam logic [MODE_W-1:0] MODE_RAINBOW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAVES   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECKER = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ON  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_OFF = 2'd3;

    // Reset values
    localparam logic [MODE_W-1:0]  RST_MODE      = MODE_RAINBOW;
    localparam logic [WIDTH_W-1:0] RST_WIDTH     = 9'd160;
    localparam logic [COLOR_W-1:0] RST_COLOR_ON  = 16'hFFFF;
    localparam logic [COLOR_W-1:0] RST_COLOR_OFF = 16'hFD20;

    // Hue wheel sectors
    localparam logic [SECT_W-1:0] SECT_RED_YEL  = 3'd0;
    localparam logic [SECT_W-1:0] SECT_YEL_GRN  = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN  = 3'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU  = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG  = 3'd4;
    localparam logic [SECT_W-1:0] SECT_MAG_RED  = 3'd5;

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic logic [WIDTH_W:0] div_step(
        input logic [WIDTH_W-1:0] rem,
        input logic               nbit,
        input logic [WIDTH_W-1:0] divisor
    );
        logic [WIDTH_W:0] trial;
        logic [WIDTH_W:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
            return {1'b1, diff[WIDTH_W-1:0]};
        else
            return {1'b0, trial[WIDTH_W-1:0]};
    endfunction

    // Bit i is the parity of floor(i / span), built by counting
    function automatic logic [255:0] cell_parity_table(input int span);
        logic [255:0] tab;
        int           cnt;
        logic         par;
        tab = '0;
        cnt = 0;
        par = 1'b0;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = par;
            cnt++;
            if (cnt == span)
            begin
                cnt = 0;
                par = ~par;
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hue_wheel_test_pattern_generator.sv =====
`default_nettype none

// Hue-wheel test pattern generator: one RGB565 pixel per beat, one beat per clock
// sustained while out_stall is low. An accepted input beat passes a capture stage and the
// rainbow divider (x*255 / line_width, a 16-step restoring divider retiring
// four quotient bits in each of four stages), followed by hue, sector and color stages.
// Every stage holds its own valid bit, so bubbles collapse under output stall and new
// pixels are taken while a finished pixel waits. Configuration is taken on any cycle
// (cfg_ready is always high) but must only be written with the pipeline empty.
module hue_wheel_test_pattern_generator
    import hwtpg_pkg::*;
#(
    parameter int MAX_COORD_BITS = DEF_MAX_COORD_BITS,
    parameter int CHECKER_CELL   = DEF_CHECKER_CELL
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [PIX_W-1:0]     pixel_x,
    input  wire logic [PIX_W-1:0]     pixel_y,
    input  wire logic [FRAME_W-1:0]   frame_count,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [COLOR_W-1:0]        pixel_color,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data
);

    localparam int CoordW  = (MAX_COORD_BITS < PIX_W) ? MAX_COORD_BITS : PIX_W;
    localparam int SHue    = DIV_STAGES + 1;
    localparam int SWheel  = DIV_STAGES + 2;
    localparam int SOut    = DIV_STAGES + 3;
    localparam int NStage  = DIV_STAGES + 4;
    localparam logic [255:0] CellTab = cell_parity_table(CHECKER_CELL);

    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [WIDTH_W-1:0] rem;
        logic [NUM_W-1:0]   quot;
        logic [CoordW-1:0]  x;
        logic [CoordW-1:0]  y;
        logic [HUE_W-1:0]   frame8;
        logic [DSUM_W-1:0]  dsum;
        logic               f0;
    } pix_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic             tile;
    } hue_t;

    typedef struct packed {
        logic [SECT_W-1:0] sect;
        logic [DIFF_W-1:0] diff;
        logic              tile;
    } wheel_t;

    // ---------------- configuration ----------------
    logic [MODE_W-1:0]  pattern_mode_reg;
    logic [WIDTH_W-1:0] line_width_reg;
    logic [COLOR_W-1:0] color_on_reg;
    logic [COLOR_W-1:0] color_off_reg;
    logic [WIDTH_W-1:0] divisor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_mode_reg <= RST_MODE;
            line_width_reg   <= RST_WIDTH;
            color_on_reg     <= RST_COLOR_ON;
            color_off_reg    <= RST_COLOR_OFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:      pattern_mode_reg <= cfg_data[MODE_W-1:0];
                REG_WIDTH:     line_width_reg   <= cfg_data[WIDTH_W-1:0];
                REG_COLOR_ON:  color_on_reg     <= cfg_data;
                REG_COLOR_OFF: color_off_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // zero width acts as one
    assign divisor = (line_width_reg == '0) ? WIDTH_W'(1) : line_width_reg;

    // ---------------- pipeline control ----------------
    logic [NStage-1:0] valid_reg;
    logic [NStage-1:0] stage_rdy;

    always_comb
    begin
        stage_rdy[NStage-1] = !valid_reg[NStage-1] || !out_stall;
        for (int k = NStage - 2; k >= 0; k--)
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
    end

    assign in_stall  = !stage_rdy[0];
    assign out_valid = valid_reg[NStage-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (stage_rdy[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NStage; k++)
                if (stage_rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // ---------------- capture stage ----------------
    pix_t             pix_reg [0:DIV_STAGES];
    pix_t             cap_next;
    logic [NUM_W-1:0] x_wide;

    always_comb
    begin
        x_wide          = NUM_W'(pixel_x[CoordW-1:0]);
        cap_next.num    = (x_wide << 8) - x_wide;
        cap_next.rem    = '0;
        cap_next.quot   = '0;
        cap_next.x      = pixel_x[CoordW-1:0];
        cap_next.y      = pixel_y[CoordW-1:0];
        cap_next.frame8 = frame_count[HUE_W-1:0];
        cap_next.f0     = frame_count[2];
        // base-4 digit sum of frame/4, which is congruent to it mod 3
        cap_next.dsum   = '0;
        for (int d = 1; d < FRAME_W / 2; d++)
            cap_next.dsum = cap_next.dsum + DSUM_W'(frame_count[2*d +: 2]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0] && in_valid)
            pix_reg[0] <= cap_next;
    end

    // ---------------- divider stages ----------------
    for (genvar g = 1; g <= DIV_STAGES; g++)
    begin : g_div
        pix_t pix_next;

        always_comb
        begin
            logic [WIDTH_W:0] st;
            pix_next = pix_reg[g-1];
            for (int j = 0; j < DIV_BITS; j++)
            begin
                st            = div_step(pix_next.rem, pix_next.num[NUM_W-1], divisor);
                pix_next.rem  = st[WIDTH_W-1:0];
                pix_next.quot = {pix_next.quot[NUM_W-2:0], st[WIDTH_W]};
                pix_next.num  = {pix_next.num[NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_rdy[g] && valid_reg[g-1])
                pix_reg[g] <= pix_next;
        end
    end

    // ---------------- hue and checker cell ----------------
    hue_t             hue_reg;
    hue_t             hue_next;
    pix_t             pd;
    logic [HUE_W-1:0] x8;
    logic [HUE_W-1:0] y8;
    logic [HUE_W-1:0] hue_rainbow;
    logic [HUE_W-1:0] hue_waves;
    logic [3:0]       dsum3;
    logic [3:0]       mod3;

    always_comb
    begin
        pd          = pix_reg[DIV_STAGES];
        x8          = HUE_W'(pd.x);
        y8          = HUE_W'(pd.y);
        hue_rainbow = pd.quot[HUE_W-1:0] + {y8[5:0], 2'b00} + pd.frame8;
        hue_waves   = {x8[6:0], 1'b0} + {y8[5:0], 2'b00} + {y8[6:0], 1'b0}
                    + {pd.frame8[6:0], 1'b0};
        hue_next.hue = (pattern_mode_reg == MODE_WAVES) ? hue_waves : hue_rainbow;

        dsum3 = 4'(pd.dsum[1:0]) + 4'(pd.dsum[3:2]) + 4'(pd.dsum[5:4]);
        if (dsum3 >= 4'd9)
            mod3 = dsum3 - 4'd9;
        else if (dsum3 >= 4'd6)
            mod3 = dsum3 - 4'd6;
        else if (dsum3 >= 4'd3)
            mod3 = dsum3 - 4'd3;
        else
            mod3 = dsum3;
        // parity of frame/12 is parity of (frame/4 - (frame/4 mod 3))
        hue_next.tile = CellTab[x8] ^ CellTab[y8] ^ pd.f0 ^ mod3[0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[SHue] && valid_reg[SHue-1])
            hue_reg <= hue_next;
    end

    // ---------------- sector split ----------------
    wheel_t           wheel_reg;
    wheel_t           wheel_next;
    logic [HUE_W-1:0] diff_full;

    always_comb
    begin
        if (hue_reg.hue >= HUE_W'(5 * HUE_SPAN))
        begin
            wheel_next.sect = SECT_MAG_RED;
            diff_full       = hue_reg.hue - HUE_W'(5 * HUE_SPAN);
        end
        else if (hue_reg.hue >= HUE_W'(4 * HUE_SPAN))
        begin
            wheel_next.sect = SECT_BLU_MAG;
            diff_full       = hue_reg.hue - HUE_W'(4 * HUE_SPAN);
        end
        else if (hue_reg.hue >= HUE_W'(3 * HUE_SPAN))
        begin
            wheel_next.sect = SECT_CYN_BLU;
            diff_full       = hue_reg.hue - HUE_W'(3 * HUE_SPAN);
        end
        else if (hue_reg.hue >= HUE_W'(2 * HUE_SPAN))
        begin
            wheel_next.sect = SECT_GRN_CYN;
            diff_full       = hue_reg.hue - HUE_W'(2 * HUE_SPAN);
        end
        else if (hue_reg.hue >= HUE_W'(HUE_SPAN))
        begin
            wheel_next.sect = SECT_YEL_GRN;
            diff_full       = hue_reg.hue - HUE_W'(HUE_SPAN);
        end
        else
        begin
            wheel_next.sect = SECT_RED_YEL;
            diff_full       = hue_reg.hue;
        end
        wheel_next.diff = diff_full[DIFF_W-1:0];
        wheel_next.tile = hue_reg.tile;
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[SWheel] && valid_reg[SWheel-1])
            wheel_reg <= wheel_next;
    end

    // ---------------- color and pack ----------------
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic [HUE_W-1:0]   ramp;
    logic [HUE_W-1:0]   red;
    logic [HUE_W-1:0]   grn;
    logic [HUE_W-1:0]   blu;

    always_comb
    begin
        ramp = {wheel_reg.diff, 2'b00} + {1'b0, wheel_reg.diff, 1'b0};
        unique case (wheel_reg.sect)
            SECT_RED_YEL: begin red = 8'hFF;  grn = ramp;  blu = 8'h00; end
            SECT_YEL_GRN: begin red = ~ramp;  grn = 8'hFF; blu = 8'h00; end
            SECT_GRN_CYN: begin red = 8'h00;  grn = 8'hFF; blu = ramp;  end
            SECT_CYN_BLU: begin red = 8'h00;  grn = ~ramp; blu = 8'hFF; end
            SECT_BLU_MAG: begin red = ramp;   grn = 8'h00; blu = 8'hFF; end
            default:      begin red = 8'hFF;  grn = 8'h00; blu = ~ramp; end
        endcase

        unique case (pattern_mode_reg) inside
            MODE_RAINBOW, MODE_WAVES: color_next = {red[7:3], grn[7:2], blu[7:3]};
            MODE_CHECKER: color_next = wheel_reg.tile ? color_on_reg : color_off_reg;
            default:      color_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[SOut] && valid_reg[SOut-1])
            color_reg <= color_next;
    end

    assign pixel_color = color_reg;

    // ---------------- assertions ----------------
    // a full pipe under output stall must hold off the input
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && out_stall) |-> in_stall)
        else $error("input taken while pipeline full and stalled");

    // an accepted beat lands in the capture stage
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted beat lost at capture");

    // the unused mode drives black
    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pattern_mode_reg != MODE_RAINBOW && pattern_mode_reg != MODE_WAVES
         && pattern_mode_reg != MODE_CHECKER) |-> (pixel_color == '0))
        else $error("unused mode gave a nonzero pixel");

endmodule

`default_nettype wire
